FILE: rtl/core/tafn_pkg.sv
`default_nettype none
package tafn_pkg;

	// Magnitude of a cleaned 16-bit component, and widths of its powers
	localparam int MAG_W = 16;
	localparam int SQ_W  = 32;
	localparam int NUM_W = 64;
	localparam int LANES = 5;

	// Lane order of the root searches
	localparam int LANE_SX = 0;
	localparam int LANE_SY = 1;
	localparam int LANE_TX = 2;
	localparam int LANE_TY = 3;
	localparam int LANE_TZ = 4;

	// Sign and special-case flags that ride along with an item
	typedef struct packed {
		logic nx_neg;
		logic ny_neg;
		logic ny_pos;
		logic nz_neg;
		logic nz_zero;
		logic h_zero;
	} side_t;

endpackage
`default_nettype wire

FILE: rtl/core/tafn_ifs.sv
`default_nettype none
interface tafn_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] normal_x;
	logic [15:0] normal_y;
	logic [15:0] normal_z;

	modport source (output valid, output normal_x, output normal_y, output normal_z,
		input ready);
	modport sink (input valid, input normal_x, input normal_y, input normal_z,
		output ready);
endinterface

interface tafn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] axis_s_x;
	logic [15:0] axis_s_y;
	logic        axis_s_z;
	logic [15:0] axis_t_x;
	logic [15:0] axis_t_y;
	logic [15:0] axis_t_z;

	modport source (output valid, output axis_s_x, output axis_s_y, output axis_s_z,
		output axis_t_x, output axis_t_y, output axis_t_z, input ready);
	modport sink (input valid, input axis_s_x, input axis_s_y, input axis_s_z,
		input axis_t_x, input axis_t_y, input axis_t_z, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tafn_cell.sv
`default_nettype none
// One result bit of one root search: try setting the bit, keep it when the
// residual N - (2q-1)^2 * den stays non-negative.
module tafn_cell #(
	parameter int FRAC_BITS = 14,
	parameter int BIT = 0,
	localparam int RW = tafn_pkg::NUM_W + 2 * FRAC_BITS + 6,
	localparam int QW = FRAC_BITS + 1
) (
	input  wire                        clk,
	input  wire                        en,
	input  wire  signed [RW-1:0]       r_in,
	input  wire  signed [RW-1:0]       p_in,
	input  wire  [tafn_pkg::NUM_W-1:0] d_in,
	input  wire  [QW-1:0]              q_in,
	input  wire                        full_in,
	output logic signed [RW-1:0]       r_out,
	output logic signed [RW-1:0]       p_out,
	output logic [tafn_pkg::NUM_W-1:0] d_out,
	output logic [QW-1:0]              q_out,
	output logic                       full_out
);
	import tafn_pkg::*;

	logic signed [RW-1:0] dw;
	logic signed [RW-1:0] r_c;
	logic                 take;

	assign dw   = {{(RW-NUM_W){1'b0}}, d_in};
	// p holds den*(2q-1); raising 2q-1 by 2^(BIT+1) costs p<<(BIT+2) + den<<(2BIT+2)
	assign r_c  = r_in - (p_in <<< (BIT + 2)) - (dw <<< (2 * BIT + 2));
	assign take = !full_in && !r_c[RW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			r_out    <= take ? r_c : r_in;
			p_out    <= take ? p_in + (dw <<< (BIT + 1)) : p_in;
			d_out    <= d_in;
			q_out    <= take ? (q_in | (QW'(1) << BIT)) : q_in;
			full_out <= full_in | (take && (BIT == FRAC_BITS));
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/texture_axis_from_normal.sv
`default_nettype none
// Channel   | Dir | Payload                                      | Handshake
// nrm       | in  | normal_x, normal_y, normal_z (s16)           | valid/ready
// axs       | out | axis_s_x/y (s16), axis_s_z (1), axis_t_x/y/z | valid/ready
// threshold | in  | threshold_wdata (u8)                         | threshold_we
//
// One item per cycle while axs does not stall. Stages in order: clean, square,
// products, seed, one cell per result bit, pack.
// The five root searches run side by side as rows of FRAC_BITS+1 cells.
// Reset clears the valid bits and the threshold; payload is not reset.
// A stall on axs freezes the whole pipe; nrm.ready drops only when the
// output register is full and not taken.
module texture_axis_from_normal #(
	parameter int FRAC_BITS = 14
) (
	input  wire        clk,
	input  wire        arst_n,
	tafn_in_if.sink    nrm,
	tafn_out_if.source axs,
	input  wire        threshold_we,
	input  wire  [7:0] threshold_wdata
);
	import tafn_pkg::*;

	localparam int RW   = NUM_W + 2 * FRAC_BITS + 6;
	localparam int QW   = FRAC_BITS + 1;
	localparam int NC   = FRAC_BITS + 1;
	localparam int NSTG = 4 + NC;
	// Signed magnitude plus room to compare against the 16-bit limits
	localparam int VW   = (FRAC_BITS > 15) ? FRAC_BITS + 2 : 17;

	logic [7:0]      thr_q;
	logic [NSTG-1:0] vld_q;
	logic            out_vld_q;
	logic            adv;

	// Hold everything while the output waits
	assign adv       = !out_vld_q || axs.ready;
	assign nrm.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (threshold_we) begin
			thr_q <= threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[NSTG-2:0], nrm.valid};
			out_vld_q <= vld_q[NSTG-1];
		end
	end

	// Stage 1: drop small components, take magnitudes
	function automatic logic [MAG_W-1:0] mag_of(input logic [15:0] v);
		mag_of = v[15] ? (~v + 16'd1) : v;
	endfunction

	logic [MAG_W-1:0] mx, my, mz;
	logic             kx, ky, kz;
	logic [MAG_W-1:0] ax_s1, ay_s1, az_s1;
	side_t            side_s1;

	assign mx = mag_of(nrm.normal_x);
	assign my = mag_of(nrm.normal_y);
	assign mz = mag_of(nrm.normal_z);
	// -32768 gives 0x8000, still above any 8-bit threshold
	assign kx = mx > MAG_W'(thr_q);
	assign ky = my > MAG_W'(thr_q);
	assign kz = mz > MAG_W'(thr_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1           <= kx ? mx : '0;
			ay_s1           <= ky ? my : '0;
			az_s1           <= kz ? mz : '0;
			side_s1.nx_neg  <= kx && nrm.normal_x[15];
			side_s1.ny_neg  <= ky && nrm.normal_y[15];
			side_s1.ny_pos  <= ky && !nrm.normal_y[15];
			side_s1.nz_neg  <= kz && nrm.normal_z[15];
			side_s1.nz_zero <= !kz;
			side_s1.h_zero  <= !kx && !ky;
		end
	end

	// Stage 2: squares
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	side_t           side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2   <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sy_s2   <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			sz_s2   <= SQ_W'(az_s1) * SQ_W'(az_s1);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: numerators and denominators of the five ratios
	logic [SQ_W-1:0]  h2, f2;
	logic [NUM_W-1:0] num_s3 [LANES];
	logic [NUM_W-1:0] den_s3 [LANES];
	side_t            side_s3;

	assign h2 = sx_s2 + sy_s2;
	assign f2 = h2 + sz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3[LANE_SX] <= NUM_W'(sy_s2);
			den_s3[LANE_SX] <= NUM_W'(h2);
			num_s3[LANE_SY] <= NUM_W'(sx_s2);
			den_s3[LANE_SY] <= NUM_W'(h2);
			num_s3[LANE_TX] <= NUM_W'(sz_s2) * NUM_W'(sx_s2);
			den_s3[LANE_TX] <= NUM_W'(f2) * NUM_W'(h2);
			num_s3[LANE_TY] <= NUM_W'(sz_s2) * NUM_W'(sy_s2);
			den_s3[LANE_TY] <= NUM_W'(f2) * NUM_W'(h2);
			num_s3[LANE_TZ] <= NUM_W'(h2);
			den_s3[LANE_TZ] <= NUM_W'(f2);
			side_s3         <= side_s2;
		end
	end

	// Stage 4 and cells: residual r = num*4^(F+1) - (2q-1)^2*den, p = den*(2q-1)
	logic signed [RW-1:0]    r_w [LANES][NC+1];
	logic signed [RW-1:0]    p_w [LANES][NC+1];
	logic [NUM_W-1:0]        d_w [LANES][NC+1];
	logic [QW-1:0]           q_w [LANES][NC+1];
	logic                    f_w [LANES][NC+1];
	side_t                   side_c [NC+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_c[0] <= side_s3;
		end
	end

	genvar ln, k;
	generate
		for (ln = 0; ln < LANES; ln++) begin : g_lane
			logic signed [RW-1:0] nw, dw;
			assign nw = {{(RW-NUM_W){1'b0}}, num_s3[ln]};
			assign dw = {{(RW-NUM_W){1'b0}}, den_s3[ln]};
			always_ff @(posedge clk) begin
				if (adv) begin
					r_w[ln][0] <= (nw <<< (2 * FRAC_BITS + 2)) - dw;
					p_w[ln][0] <= -dw;
					d_w[ln][0] <= den_s3[ln];
					q_w[ln][0] <= '0;
					f_w[ln][0] <= 1'b0;
				end
			end
			for (k = 0; k < NC; k++) begin : g_bit
				tafn_cell #(.FRAC_BITS(FRAC_BITS), .BIT(FRAC_BITS - k)) u_cell (
					.clk      (clk),
					.en       (adv),
					.r_in     (r_w[ln][k]),
					.p_in     (p_w[ln][k]),
					.d_in     (d_w[ln][k]),
					.q_in     (q_w[ln][k]),
					.full_in  (f_w[ln][k]),
					.r_out    (r_w[ln][k+1]),
					.p_out    (p_w[ln][k+1]),
					.d_out    (d_w[ln][k+1]),
					.q_out    (q_w[ln][k+1]),
					.full_out (f_w[ln][k+1])
				);
			end
		end
		for (k = 0; k < NC; k++) begin : g_side
			always_ff @(posedge clk) begin
				if (adv) begin
					side_c[k+1] <= side_c[k];
				end
			end
		end
	endgenerate

	// Output stage: apply sign, saturate to 16 bits, patch the vertical case
	function automatic logic [15:0] pack16(input logic neg, input logic [QW-1:0] mag);
		logic signed [VW-1:0] v;
		v = VW'($signed({1'b0, mag}));
		if (neg)
			v = -v;
		if (v > VW'(32767))
			pack16 = 16'h7FFF;
		else if (v < -VW'(32768))
			pack16 = 16'h8000;
		else
			pack16 = v[15:0];
	endfunction

	localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

	side_t       sd;
	logic [15:0] sx_o, sy_o, tx_o, ty_o, tz_o;

	assign sd = side_c[NC];

	always_comb begin
		if (sd.h_zero) begin
			sx_o = '0;
			sy_o = pack16(1'b0, ONE);
			tx_o = pack16(sd.nz_neg, sd.nz_zero ? '0 : ONE);
			ty_o = '0;
			tz_o = pack16(sd.nz_zero, sd.nz_zero ? ONE : '0);
		end else begin
			sx_o = pack16(sd.ny_pos, q_w[LANE_SX][NC]);
			sy_o = pack16(sd.nx_neg, q_w[LANE_SY][NC]);
			tx_o = pack16(sd.nz_neg ^ sd.nx_neg, q_w[LANE_TX][NC]);
			ty_o = pack16(sd.nz_neg ^ sd.ny_neg, q_w[LANE_TY][NC]);
			tz_o = pack16(1'b1, q_w[LANE_TZ][NC]);
		end
	end

	logic [15:0] sx_q, sy_q, tx_q, ty_q, tz_q;
	logic        hz_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q <= sx_o;
			sy_q <= sy_o;
			tx_q <= tx_o;
			ty_q <= ty_o;
			tz_q <= tz_o;
			hz_q <= sd.h_zero;
		end
	end

	assign axs.valid    = out_vld_q;
	assign axs.axis_s_x = sx_q;
	assign axs.axis_s_y = sy_q;
	assign axs.axis_s_z = 1'b0;
	assign axs.axis_t_x = tx_q;
	assign axs.axis_t_y = ty_q;
	assign axs.axis_t_z = tz_q;

	// Vertical normal: first axis must be exactly (0, 1, 0)
	a_vertical_s: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && hz_q |-> sx_q == '0 && sy_q == pack16(1'b0, ONE))
		else $error("vertical normal gave wrong first axis");

	// Third component of the second axis is never positive
	a_tz_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> $signed(tz_q) <= 0)
		else $error("axis_t_z positive");

	// A stall freezes the valid pipe
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q) && out_vld_q)
		else $error("pipe moved during stall");

	// An accepted item shows up in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		nrm.valid && adv |=> vld_q[0])
		else $error("accepted item lost");
endmodule
`default_nettype wire

FILE: test/tb_texture_axis_from_normal.sv
`timescale 1ns / 1ps
module tb_texture_axis_from_normal;
	import tafn_pkg::*;

	localparam int FRAC     = 14;
	localparam int LATENCY  = FRAC + 6;
	localparam int WATCHDOG = 5000;
	localparam int THR_MAX  = 255;

	// One texture-axis pair as it leaves the block
	typedef struct {
		logic [15:0] s_x;
		logic [15:0] s_y;
		logic        s_z;
		logic [15:0] t_x;
		logic [15:0] t_y;
		logic [15:0] t_z;
	} axes_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic threshold_we = 1'b0;
	logic [7:0] threshold_wdata = '0;

	tafn_in_if  nrm ();
	tafn_out_if axs ();

	texture_axis_from_normal #(.FRAC_BITS(FRAC)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.nrm(nrm),
		.axs(axs),
		.threshold_we(threshold_we),
		.threshold_wdata(threshold_wdata)
	);

	always #5 clk = ~clk;

	// Testbench copy of the threshold register
	int unsigned cur_threshold = 0;
	// Axes still owed by the block, oldest first
	axes_t pending_axes[$];
	int errors = 0;
	// Idle and stall percentages for the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Cycles the receiver still holds ready low
	int hold_off = 0;
	int quiet_cycles = 0;

	initial begin
		nrm.valid = 1'b0;
		nrm.normal_x = '0;
		nrm.normal_y = '0;
		nrm.normal_z = '0;
		axs.ready = 1'b0;
	end

	// round(2^FRAC * sqrt(num/den)) by bisection on the square compare
	function automatic longint unsigned root_ratio(longint unsigned num,
		longint unsigned den);
		longint unsigned lo, hi, mid;
		logic [127:0] lhs, rhs, t;
		lo = 0;
		hi = longint'(1) << FRAC;
		if (den == 0)
			return 0;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			t = 128'(2 * mid - 1);
			lhs = t * t * 128'(den);
			rhs = 128'(num) << (2 * FRAC + 2);
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Apply the sign and saturate to 16 signed bits
	function automatic logic [15:0] signed_axis(bit neg, longint unsigned mag);
		longint v;
		v = neg ? -longint'(mag) : longint'(mag);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// Clear a component at or below the threshold
	function automatic longint cleaned(logic [15:0] raw);
		longint v;
		v = longint'($signed(raw));
		return ((v < 0 ? -v : v) <= cur_threshold) ? 0 : v;
	endfunction

	function automatic axes_t predict_axes(logic [15:0] rx, logic [15:0] ry,
		logic [15:0] rz);
		longint nx, ny, nz;
		longint unsigned sx2, sy2, sz2, h2, f2;
		axes_t a;
		nx = cleaned(rx);
		ny = cleaned(ry);
		nz = cleaned(rz);
		sx2 = nx * nx;
		sy2 = ny * ny;
		sz2 = nz * nz;
		h2 = sx2 + sy2;
		f2 = h2 + sz2;
		a.s_z = 1'b0;
		if (h2 == 0) begin
			// Vertical or zero normal: azimuth taken as zero
			a.s_x = signed_axis(0, 0);
			a.s_y = signed_axis(0, longint'(1) << FRAC);
			a.t_x = signed_axis(nz < 0, nz != 0 ? longint'(1) << FRAC : 0);
			a.t_y = signed_axis(0, 0);
			a.t_z = signed_axis(nz == 0, nz == 0 ? longint'(1) << FRAC : 0);
		end else begin
			a.s_x = signed_axis(ny > 0, root_ratio(sy2, h2));
			a.s_y = signed_axis(nx < 0, root_ratio(sx2, h2));
			a.t_x = signed_axis((nz < 0) != (nx < 0), root_ratio(sz2 * sx2, f2 * h2));
			a.t_y = signed_axis((nz < 0) != (ny < 0), root_ratio(sz2 * sy2, f2 * h2));
			a.t_z = signed_axis(1, root_ratio(h2, f2));
		end
		return a;
	endfunction

	// Offer one normal; return at the edge where it is taken.
	// Valid is left high so a back-to-back item goes with no gap.
	task automatic send_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			nrm.valid <= 1'b0;
			@(posedge clk);
		end
		nrm.valid <= 1'b1;
		nrm.normal_x <= x;
		nrm.normal_y <= y;
		nrm.normal_z <= z;
		do
			@(posedge clk);
		while (!nrm.ready);
		pending_axes.push_back(predict_axes(x, y, z));
	endtask

	// Drop valid and wait for every owed result plus the pipe depth
	task automatic drain;
		nrm.valid <= 1'b0;
		@(posedge clk);
		wait (pending_axes.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Write the threshold while the block is idle
	task automatic set_threshold(int unsigned value);
		drain();
		threshold_we <= 1'b1;
		threshold_wdata <= value[7:0];
		@(posedge clk);
		threshold_we <= 1'b0;
		cur_threshold = value;
	endtask

	// Random component: half full range, some near the threshold, a few zeros and extremes
	function automatic logic [15:0] rand_component();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 5)
			return 16'($urandom);
		else if (pick < 8)
			return 16'($signed($urandom_range(600)) - 300);
		else if (pick < 9)
			return 16'(0);
		else
			return $urandom_range(1) ? 16'h8000 : 16'h7fff;
	endfunction

	task automatic send_random(int count);
		repeat (count)
			send_normal(rand_component(), rand_component(), rand_component());
	endtask

	task automatic test_directed;
		set_threshold(0);
		send_normal(16'd0, 16'd0, 16'd0);
		send_normal(16'h7fff, 16'd0, 16'd0);
		send_normal(16'h8000, 16'd0, 16'd0);
		send_normal(16'd0, 16'h7fff, 16'd0);
		send_normal(16'd0, 16'h8000, 16'd0);
		send_normal(16'd0, 16'd0, 16'h7fff);
		send_normal(16'd0, 16'd0, 16'h8000);
		send_normal(16'h8000, 16'h8000, 16'h8000);
		send_normal(16'h7fff, 16'h7fff, 16'h7fff);
		send_normal(16'd1, 16'd1, 16'd1);
		send_normal(16'hffff, 16'hffff, 16'hffff);
		send_normal(16'd3, 16'hfffc, 16'd5);
		send_normal(16'd1, 16'd0, 16'd0);
		send_normal(16'h8000, 16'h7fff, 16'hffff);
		// Largest threshold: small parts vanish, the most negative value never does
		set_threshold(THR_MAX);
		send_normal(16'd255, 16'hff01, 16'd255);
		send_normal(16'd256, 16'hff00, 16'd0);
		send_normal(16'd255, 16'd0, 16'hff00);
		send_normal(16'h8000, 16'h8000, 16'h8000);
		send_normal(16'd100, 16'd200, 16'h8000);
	endtask

	// One random phase per idling pattern, each with the threshold written anew
	task automatic test_random_phases;
		int unsigned thr[4] = '{0, 255, 0, 0};
		thr[2] = $urandom_range(1, 254);
		thr[3] = $urandom_range(1, 254);
		for (int p = 0; p < 4; p++) begin
			set_threshold(thr[p]);
			send_idle_pct = (p == 1) ? 58 : (p == 3) ? 6 : 0;
			recv_stall_pct = (p == 2) ? 58 : (p == 3) ? 6 : 0;
			send_random(400);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Hold the receiver off long enough for the pipe to fill and stall input
	task automatic test_backpressure;
		hold_off = 4 * LATENCY + 100;
		send_random(80);
	endtask

	// Pause the sender until every owed result has come, then resume
	task automatic test_sender_pause;
		send_random(20);
		nrm.valid <= 1'b0;
		@(posedge clk);
		wait (pending_axes.size() == 0);
		@(posedge clk);
		send_random(20);
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %0d got %0d", name, $signed(exp_v), $signed(act_v));
			errors++;
		end
	endtask

	// Receiver: randomize ready, honor a hold-off, check each accepted result
	always @(posedge clk) begin
		axes_t e;
		if (arst_n && axs.valid && axs.ready) begin
			if (pending_axes.size() == 0) begin
				$error("result with no pending normal");
				errors++;
			end else begin
				e = pending_axes.pop_front();
				check_field("axis_s_x", e.s_x, axs.axis_s_x);
				check_field("axis_s_y", e.s_y, axs.axis_s_y);
				check_field("axis_s_z", 16'(e.s_z), 16'(axs.axis_s_z));
				check_field("axis_t_x", e.t_x, axs.axis_t_x);
				check_field("axis_t_y", e.t_y, axs.axis_t_y);
				check_field("axis_t_z", e.t_z, axs.axis_t_z);
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			axs.ready <= 1'b0;
		end else begin
			axs.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: count cycles where neither side moves an item
	always @(posedge clk) begin
		if ((nrm.valid && nrm.ready) || (axs.valid && axs.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("tb_texture_axis_from_normal NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		drain();
		if (errors == 0 && pending_axes.size() == 0)
			$display("tb_texture_axis_from_normal OK");
		else
			$display("tb_texture_axis_from_normal NOT OK");
		$finish;
	end
endmodule

FILE: files.f
rtl/core/tafn_pkg.sv
rtl/core/tafn_ifs.sv
rtl/core/tafn_cell.sv
rtl/core/texture_axis_from_normal.sv
test/tb_texture_axis_from_normal.sv
